/* design/rac_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rac_pkg: shared types and codes
// Mode, status and order codes, and the command/status structs that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package rac_pkg;
  localparam int W  = 32;
  localparam int DW = 2 * W;

  localparam logic [2:0] MODE_LOAD = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;
  localparam logic [2:0] MODE_CMP  = 3'd5;
  localparam logic [2:0] MODE_NEG  = 3'd6;
  localparam logic [2:0] MODE_RSVD = 3'd7; // unused: accumulator kept

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_op;   // capture operand, split signs
    logic mul1;      // first cross products
    logic mul2;      // second cross products
    logic combine;   // sum / compare, set up gcd
    logic gcd_step;  // one remainder step
    logic div_start; // start dividing by the gcd
    logic div_step;  // one quotient bit for numerator and denominator
    logic commit;    // range check and write back
    logic push;      // copy the finished word to the output register
  } rac_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;     // result is already settled after combine, or after the first gcd step for a zero result
    logic gcd_done;
    logic div_done;
  } rac_sts_t;
endpackage

/* design/rac_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rac_in_if / rac_out_if: valid/ready channels
// One word per accepted handshake.
// ---------------------------------------------------------------------------
interface rac_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [31:0] operand_num;
  logic signed [31:0] operand_den;
  modport source (output valid, mode, operand_num, operand_den, input ready);
  modport sink   (input valid, mode, operand_num, operand_den, output ready);
endinterface

interface rac_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] result_num;
  logic [30:0]       result_den;
  logic [1:0]        order;
  logic [1:0]        status;
  modport source (output valid, result_num, result_den, order, status, input ready);
  modport sink   (input valid, result_num, result_den, order, status, output ready);
endinterface

/* design/rac_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rac_ctrl: sequencing state machine
// Steps one word through multiply, combine, gcd, divide and commit.
// ---------------------------------------------------------------------------
module rac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_fire,
  input  rac_pkg::rac_sts_t sts,
  output rac_pkg::rac_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import rac_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_COMB = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_CMT  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_op = in_fire;
        if (in_fire) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        if (sts.early) state_nxt = S_OUT;
        else if (sts.gcd_done) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else cmd.gcd_step = 1'b1;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_CMT;
        else cmd.div_step = 1'b1;
      end
      S_CMT: begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hand the word over once the output register is free
        if (!out_valid_r || out_fire) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register: fill on push, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) out_valid_nxt = 1'b1;
    else if (out_fire) out_valid_nxt = 1'b0;
  end

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == S_IDLE) else $error("word taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fire |=> out_valid) else $error("result dropped");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_MUL1) else $error("no start");
endmodule

/* design/rac_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rac_dp: arithmetic datapath
// Sign-magnitude cross products, add/compare, remainder-based Euclid
// and restoring division by the gcd, with the accumulator registers.
// ---------------------------------------------------------------------------
module rac_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rac_pkg::rac_cmd_t  cmd,
  output rac_pkg::rac_sts_t  sts,
  input  logic [2:0]         mode,
  input  logic signed [31:0] operand_num,
  input  logic signed [31:0] operand_den,
  output logic signed [31:0] result_num,
  output logic [30:0]        result_den,
  output logic [1:0]         order,
  output logic [1:0]         status
);
  import rac_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic signed [W-1:0] acc_num_r;
  logic [W-1:0]        acc_den_r;
  logic [2:0]          mode_r;
  logic                sop_r, sa_r;
  logic [W-1:0]        mn_r, md_r, ma_r;
  logic [DW-1:0]       p1_r, p2_r, p3_r; // ma*md, mn*da, ma*mn (or chosen pair)
  logic [DW-1:0]       p4_r;             // da*md
  logic                neg_r;
  logic [DW-1:0]       mag_r, den_r;     // result before reduction
  logic [DW-1:0]       ga_r, gb_r;       // euclid pair
  logic [DW-1:0]       rem_r;            // remainder under way
  logic [CW-1:0]       cnt_r;
  logic                remb_r;           // remainder step active
  logic [DW-1:0]       qn_r, qd_r, rn_r, rd_r;
  logic [1:0]          order_r, status_r;
  logic                early_r;
  logic signed [W-1:0] res_num_r;        // output word register
  logic [30:0]         res_den_r;
  logic [1:0]          res_order_r, res_status_r;

  logic [W:0]  mn_w, md_w;
  logic [W-1:0] ma_w;
  logic         sn_w, sd_w;
  assign sn_w = operand_num[W-1];
  assign sd_w = operand_den[W-1];
  assign mn_w = sn_w ? ({1'b0, ~operand_num} + 1'b1) : {1'b0, operand_num};
  assign md_w = sd_w ? ({1'b0, ~operand_den} + 1'b1) : {1'b0, operand_den};
  assign ma_w = acc_num_r[W-1] ? (~acc_num_r + 1'b1) : acc_num_r;

  // sum and compare on the registered products
  logic          s2;
  logic [DW-1:0] sum_w;
  logic          sneg_w;
  logic [1:0]    ord_w;
  always_comb begin
    s2 = (mode_r == MODE_SUB) ? ~sop_r : sop_r;
    if (mn_r == '0) s2 = 1'b0;
    if (sa_r == s2) begin
      sum_w = p1_r + p2_r; sneg_w = sa_r;
    end else if (p1_r >= p2_r) begin
      sum_w = p1_r - p2_r; sneg_w = sa_r;
    end else begin
      sum_w = p2_r - p1_r; sneg_w = s2;
    end
    if (sum_w == '0) sneg_w = 1'b0;
    if (sa_r != sop_r) ord_w = sa_r ? ORD_LT : ORD_GT;
    else if (p1_r == p2_r) ord_w = ORD_EQ;
    else if (sa_r) ord_w = (p1_r > p2_r) ? ORD_LT : ORD_GT;
    else ord_w = (p1_r > p2_r) ? ORD_GT : ORD_LT;
  end

  // one restoring step of rem_r mod gb_r uses a shifting divisor image
  logic [DW:0]   dv_r;   // gb shifted
  logic [DW:0]   rtry;
  assign rtry = {1'b0, rem_r} - dv_r;

  // restoring division of mag and den by g, one bit per cycle
  logic [DW:0] tn, td;
  assign tn = {rn_r, qn_r[DW-1]} - {1'b0, ga_r};
  assign td = {rd_r, qd_r[DW-1]} - {1'b0, ga_r};

  logic [DW-1:0] lim;
  assign lim = DW'(1) << (W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_num_r <= '0;
      acc_den_r <= W'(1);
      early_r   <= 1'b0;
      remb_r    <= 1'b0;
    end else begin
      // capture operand
      if (cmd.load_op) begin
        mode_r   <= mode;
        mn_r     <= mn_w[W-1:0];
        md_r     <= md_w[W-1:0];
        ma_r     <= ma_w;
        sa_r     <= acc_num_r[W-1];
        sop_r    <= (sn_w != sd_w) && (mn_w != '0);
        order_r  <= ORD_LT;
        status_r <= ST_OK;
        early_r  <= 1'b0;
        remb_r   <= 1'b0;
      end
      // cross products, one multiplier pair per cycle
      if (cmd.mul1) begin
        p1_r <= DW'(ma_r) * DW'(md_r);
        p2_r <= DW'(mn_r) * DW'(acc_den_r);
      end
      if (cmd.mul2) begin
        p3_r <= (mode_r == MODE_DIV) ? DW'(acc_den_r) * DW'(mn_r)
                                     : DW'(ma_r) * DW'(mn_r);
        p4_r <= DW'(acc_den_r) * DW'(md_r);
      end
      // choose result and prepare euclid
      if (cmd.combine) begin
        if (mode_r <= MODE_CMP && md_r == '0) begin
          status_r <= ST_ZERO;
          early_r  <= 1'b1;
        end else begin
          unique case (mode_r)
            MODE_LOAD: begin
              neg_r <= sop_r; mag_r <= DW'(mn_r); den_r <= DW'(md_r); early_r <= 1'b0;
            end
            MODE_ADD, MODE_SUB: begin
              neg_r <= sneg_w; mag_r <= sum_w; den_r <= p4_r; early_r <= 1'b0;
            end
            MODE_MUL: begin
              neg_r <= sa_r != sop_r; mag_r <= p3_r; den_r <= p4_r; early_r <= 1'b0;
            end
            MODE_DIV: begin
              if (mn_r == '0) begin
                status_r <= ST_ZERO;
                early_r  <= 1'b1;
              end else begin
                neg_r <= sa_r != sop_r; mag_r <= p1_r; den_r <= p3_r; early_r <= 1'b0;
              end
            end
            MODE_CMP: begin
              order_r <= ord_w;
              early_r <= 1'b1;
            end
            MODE_NEG: begin
              neg_r <= ~sa_r; mag_r <= DW'(ma_r); den_r <= DW'(acc_den_r);
              early_r <= 1'b0;
            end
            default: early_r <= 1'b1;
          endcase
        end
      end
      // euclid: ga, gb; rem by shift-subtract
      if (cmd.combine) begin
        unique case (mode_r)
          MODE_LOAD: begin ga_r <= DW'(mn_r); gb_r <= DW'(md_r); end
          MODE_ADD, MODE_SUB: begin ga_r <= sum_w; gb_r <= p4_r; end
          MODE_MUL: begin ga_r <= p3_r; gb_r <= p4_r; end
          MODE_DIV: begin ga_r <= p1_r; gb_r <= p3_r; end
          default: begin ga_r <= DW'(ma_r); gb_r <= DW'(acc_den_r); end
        endcase
      end
      // zero result commits 0/1 directly
      if (cmd.gcd_step && mag_r == '0) begin
        acc_num_r <= '0;
        acc_den_r <= W'(1);
        early_r   <= 1'b1;
      end else if (cmd.gcd_step) begin
        if (!remb_r) begin
          // start remainder: align divisor up
          rem_r  <= ga_r;
          dv_r   <= {1'b0, gb_r};
          remb_r <= 1'b1;
          cnt_r  <= '0;
        end else if (dv_r[DW-1:0] <= rem_r[DW-1:0] && !dv_r[DW-1] && cnt_r == '0
                     && (dv_r << 1) <= {1'b0, rem_r}) begin
          dv_r <= dv_r << 1;
        end else if (rtry[DW] == 1'b0) begin
          rem_r <= rtry[DW-1:0];
          if (dv_r == {1'b0, gb_r}) begin
            remb_r <= 1'b0; ga_r <= gb_r; gb_r <= rtry[DW-1:0];
          end else begin
            dv_r <= dv_r >> 1; cnt_r <= CW'(1);
          end
        end else begin
          if (dv_r == {1'b0, gb_r}) begin
            remb_r <= 1'b0; ga_r <= gb_r; gb_r <= rem_r;
          end else begin
            dv_r <= dv_r >> 1; cnt_r <= CW'(1);
          end
        end
      end
      // divide numerator and denominator by the gcd
      if (cmd.div_start) begin
        qn_r <= mag_r; qd_r <= den_r; rn_r <= '0; rd_r <= '0; cnt_r <= '0;
      end
      if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
        if (!tn[DW]) begin rn_r <= tn[DW-1:0]; qn_r <= {qn_r[DW-2:0], 1'b1}; end
        else begin rn_r <= {rn_r[DW-2:0], qn_r[DW-1]}; qn_r <= {qn_r[DW-2:0], 1'b0}; end
        if (!td[DW]) begin rd_r <= td[DW-1:0]; qd_r <= {qd_r[DW-2:0], 1'b1}; end
        else begin rd_r <= {rd_r[DW-2:0], qd_r[DW-1]}; qd_r <= {qd_r[DW-2:0], 1'b0}; end
      end
      // range check and write back
      if (cmd.commit) begin
        if (qd_r > lim - 1'b1 || (neg_r ? qn_r > lim : qn_r > lim - 1'b1))
          status_r <= ST_OVF;
        else begin
          acc_num_r <= neg_r ? W'(~qn_r + 1'b1) : W'(qn_r);
          acc_den_r <= W'(qd_r);
        end
      end
      // hold the finished word for the receiver
      if (cmd.push) begin
        res_num_r    <= acc_num_r;
        res_den_r    <= acc_den_r[30:0];
        res_order_r  <= order_r;
        res_status_r <= status_r;
      end
    end
  end

  assign sts.early    = early_r;
  assign sts.gcd_done = (gb_r == '0) && !remb_r;
  assign sts.div_done = (cnt_r == CW'(DW));

  assign result_num = res_num_r;
  assign result_den = res_den_r;
  assign order      = res_order_r;
  assign status     = res_status_r;

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    acc_den_r != '0) else $error("zero denominator held");
  a_cmp_keep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.combine && mode_r == MODE_CMP |=> $stable(acc_num_r))
    else $error("compare changed accumulator");
  a_ovf_keep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && qd_r > lim - 1'b1 |=> $stable(acc_den_r))
    else $error("overflow wrote back");
endmodule

/* design/rational_accumulator_alu_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_accumulator_alu_core: reduced fraction accumulator
// Loads, adds, subtracts, multiplies, divides, compares and negates a
// fraction held in lowest terms.
// ---------------------------------------------------------------------------
// One word at a time: an arithmetic word runs Euclid's gcd over the 64-bit
// products (per remainder a start step, then one shift or one subtract per
// cycle) and then a bit-serial division of numerator and denominator by the
// gcd. Compare, error cases and the unused mode finish right after combine,
// zero results after the first gcd step. The finished word moves into an
// output register and the next word can be taken in the cycle after; a
// second finished word waits until the first is taken, stalling the input.
module rational_accumulator_alu_core (
  input logic   clk,
  input logic   rst_n,
  rac_in_if.sink    in_ch,
  rac_out_if.source out_ch
);
  import rac_pkg::*;

  rac_cmd_t cmd;
  rac_sts_t sts;
  logic     busy;
  logic     in_fire, out_fire;

  assign in_ch.ready = !busy;
  assign in_fire     = in_ch.valid && !busy;
  assign out_fire    = out_ch.valid && out_ch.ready;

  rac_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts, .cmd, .busy,
    .out_valid(out_ch.valid)
  );

  rac_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .mode(in_ch.mode), .operand_num(in_ch.operand_num),
    .operand_den(in_ch.operand_den),
    .result_num(out_ch.result_num), .result_den(out_ch.result_den),
    .order(out_ch.order), .status(out_ch.status)
  );
endmodule
